[design/pgmp_pkg.sv]
// pgmp_pkg: item types, character codes and result codes for the pgm p5 stream parser
// depends on nothing; imported by every module of the parser
package pgmp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } pgmp_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pixel;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  error_code;
        logic        last_pixel;
    } pgmp_out_t;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_MAGIC  = 3'd0,
        ERR_NUMBER = 3'd1,
        ERR_MAXVAL = 3'd2,
        ERR_TRUNC  = 3'd3,
        ERR_LARGE  = 3'd4
    } err_t;

    typedef enum logic [4:0] {
        PH_SKIP    = 5'b00001,
        PH_COMMENT = 5'b00010,
        PH_TOKEN   = 5'b00100,
        PH_PIXELS  = 5'b01000,
        PH_WAIT    = 5'b10000
    } phase_t;

    typedef enum logic [3:0] {
        TOK_MAGIC  = 4'b0001,
        TOK_WIDTH  = 4'b0010,
        TOK_HEIGHT = 4'b0100,
        TOK_MAXVAL = 4'b1000
    } tok_t;

    typedef enum logic [1:0] {
        MG_NONE = 2'd0,
        MG_P    = 2'd1,
        MG_P5   = 2'd2,
        MG_BAD  = 2'd3
    } magic_t;

    typedef enum logic [1:0] {
        WF_NONE   = 2'd0,
        WF_NONPOS = 2'd1,
        WF_LARGE  = 2'd2
    } wfault_t;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [31:0] MAXVAL_OK = 32'd255;
    localparam logic [31:0] ACC_GUARD = 32'd214748364;
    localparam logic [31:0] ACC_LIMIT = 32'd2147483648;

    function automatic logic pgm_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_NL) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

[design/pgmp_in_reg.sv]
// pgmp_in_reg: input register of the parser, holds one accepted item
// depends on pgmp_pkg
module pgmp_in_reg
    import pgmp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pgmp_in_t s_data,
    input  logic     out_free,
    output logic     fire,
    output pgmp_in_t item
);

    logic     valid_reg;
    logic     valid_next;
    pgmp_in_t item_reg;

    assign fire    = valid_reg && out_free;
    assign s_ready = !valid_reg || out_free;
    assign item    = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

[design/pgmp_core.sv]
// pgmp_core: parser state and the per-item update logic
// depends on pgmp_pkg; fed by pgmp_in_reg, drives pgmp_out_reg
module pgmp_core
    import pgmp_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  pgmp_in_t  item,
    output logic      res_valid,
    output pgmp_out_t res
);

    localparam int PROD_BITS = 2 * DIM_BITS;

    phase_t                 phase_reg, phase_next;
    tok_t                   tok_reg, tok_next;
    magic_t                 magic_reg, magic_next;
    logic [31:0]            acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   digit_reg, digit_next;
    logic                   bad_reg, bad_next;
    logic                   started_reg, started_next;
    logic [DIM_BITS-1:0]    width_reg, width_next;
    wfault_t                wf_reg, wf_next;
    logic [DIM_BITS-1:0]    height_reg, height_next;
    logic [PROD_BITS-1:0]   left_reg, left_next;
    logic [PROD_BITS-1:0]   prod_reg;

    logic [7:0]  b;
    logic        b_space;
    logic        b_hash;
    logic        b_digit;
    logic [7:0]  digit;
    logic [31:0] acc_mul;
    logic        num_bad;
    logic        nonpos;
    logic        too_large;
    logic        tok_err_valid;
    err_t        tok_err;
    logic        take;
    logic        end_tok;
    logic        clear_all;
    logic        last;
    logic [15:0] width_ext;
    logic [15:0] height_ext;

    assign b          = item.in_byte;
    assign b_space    = pgm_blank(b);
    assign b_hash     = (b == CH_HASH);
    assign b_digit    = (b >= CH_0) && (b <= CH_9);
    assign digit      = b - CH_0;
    assign acc_mul    = (acc_reg << 3) + (acc_reg << 1) + 32'(digit);
    assign num_bad    = bad_reg || !digit_reg || (!neg_reg && acc_reg[31]);
    assign nonpos     = neg_reg || (acc_reg == 32'd0);
    assign too_large  = (acc_reg >> DIM_BITS) != 32'd0;
    assign width_ext  = 16'(width_reg);
    assign height_ext = 16'(height_reg);
    assign last       = (left_reg >> 1) == '0;

    // evaluation of the token held in the token registers
    always_comb begin
        tok_err_valid = 1'b0;
        tok_err       = ERR_NUMBER;
        case (tok_reg)
            TOK_MAGIC: begin
                if (magic_reg != MG_P5) begin
                    tok_err_valid = 1'b1;
                    tok_err       = ERR_MAGIC;
                end
            end
            TOK_WIDTH: begin
                tok_err_valid = num_bad;
            end
            TOK_HEIGHT: begin
                if (num_bad || nonpos || wf_reg == WF_NONPOS) begin
                    tok_err_valid = 1'b1;
                end else if (too_large || wf_reg == WF_LARGE) begin
                    tok_err_valid = 1'b1;
                    tok_err       = ERR_LARGE;
                end
            end
            TOK_MAXVAL: begin
                if (num_bad) begin
                    tok_err_valid = 1'b1;
                end else if (neg_reg || acc_reg != MAXVAL_OK) begin
                    tok_err_valid = 1'b1;
                    tok_err       = ERR_MAXVAL;
                end
            end
            default: begin
                tok_err_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        tok_next     = tok_reg;
        magic_next   = magic_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        digit_next   = digit_reg;
        bad_next     = bad_reg;
        started_next = started_reg;
        width_next   = width_reg;
        wf_next      = wf_reg;
        height_next  = height_reg;
        left_next    = left_reg;
        res_valid    = 1'b0;
        res          = '0;
        take         = 1'b0;
        end_tok      = 1'b0;
        clear_all    = 1'b0;

        if (fire) begin
            if (item.is_end) begin
                clear_all = 1'b1;
                case (phase_reg)
                    PH_PIXELS: begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_TRUNC;
                    end
                    PH_WAIT: begin
                        res_valid = 1'b0;
                    end
                    default: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_ERROR;
                        if (tok_err_valid) begin
                            res.error_code = tok_err;
                        end else if (tok_reg == TOK_MAXVAL) begin
                            res.error_code = ERR_TRUNC;
                        end else begin
                            res.error_code = ERR_NUMBER;
                        end
                    end
                endcase
            end else begin
                case (phase_reg)
                    PH_SKIP: begin
                        if (b_hash) begin
                            phase_next = PH_COMMENT;
                        end else if (!b_space) begin
                            phase_next = PH_TOKEN;
                            take       = 1'b1;
                        end
                    end
                    PH_COMMENT: begin
                        if (b == CH_NL) begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_TOKEN: begin
                        if (b_space || b_hash) begin
                            end_tok = 1'b1;
                            if (tok_err_valid) begin
                                phase_next     = PH_WAIT;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = tok_err;
                            end else if (tok_reg == TOK_MAXVAL) begin
                                res_valid = 1'b1;
                                if (!b_space) begin
                                    phase_next     = PH_WAIT;
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_TRUNC;
                                end else begin
                                    phase_next       = PH_PIXELS;
                                    left_next        = prod_reg;
                                    res.kind         = KIND_HEADER;
                                    res.image_width  = width_ext;
                                    res.image_height = height_ext;
                                end
                            end else begin
                                phase_next = b_hash ? PH_COMMENT : PH_SKIP;
                            end
                        end else begin
                            take = 1'b1;
                        end
                    end
                    PH_PIXELS: begin
                        if (left_reg != '0) begin
                            left_next = left_reg - PROD_BITS'(1);
                        end
                        if (last) begin
                            phase_next = PH_WAIT;
                        end
                        res_valid      = 1'b1;
                        res.kind       = KIND_PIXEL;
                        res.pixel      = b;
                        res.last_pixel = last;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (take) begin
            if (tok_reg == TOK_MAGIC) begin
                if (magic_reg == MG_NONE && b == CH_P) begin
                    magic_next = MG_P;
                end else if (magic_reg == MG_P && b == CH_5) begin
                    magic_next = MG_P5;
                end else begin
                    magic_next = MG_BAD;
                end
            end else begin
                if (!started_reg && (b == CH_PLUS || b == CH_MINUS)) begin
                    neg_next = (b == CH_MINUS);
                end else if (b_digit) begin
                    digit_next = 1'b1;
                    if (!bad_reg) begin
                        if (acc_reg > ACC_GUARD) begin
                            bad_next = 1'b1;
                        end else begin
                            acc_next = acc_mul;
                            if (acc_mul > ACC_LIMIT) begin
                                bad_next = 1'b1;
                            end
                        end
                    end
                end else begin
                    bad_next = 1'b1;
                end
                started_next = 1'b1;
            end
        end

        if (end_tok) begin
            if (tok_reg == TOK_WIDTH && !tok_err_valid) begin
                width_next = acc_reg[DIM_BITS-1:0];
                if (nonpos) begin
                    wf_next = WF_NONPOS;
                end else if (too_large) begin
                    wf_next = WF_LARGE;
                end else begin
                    wf_next = WF_NONE;
                end
            end
            if (tok_reg == TOK_HEIGHT && !tok_err_valid) begin
                height_next = acc_reg[DIM_BITS-1:0];
            end
            magic_next   = MG_NONE;
            acc_next     = '0;
            neg_next     = 1'b0;
            digit_next   = 1'b0;
            bad_next     = 1'b0;
            started_next = 1'b0;
            case (tok_reg)
                TOK_MAGIC:  tok_next = TOK_WIDTH;
                TOK_WIDTH:  tok_next = TOK_HEIGHT;
                TOK_HEIGHT: tok_next = TOK_MAXVAL;
                default:    tok_next = TOK_MAGIC;
            endcase
        end

        // end marker: back to the state after reset
        if (clear_all) begin
            phase_next   = PH_SKIP;
            tok_next     = TOK_MAGIC;
            magic_next   = MG_NONE;
            acc_next     = '0;
            neg_next     = 1'b0;
            digit_next   = 1'b0;
            bad_next     = 1'b0;
            started_next = 1'b0;
            width_next   = '0;
            wf_next      = WF_NONE;
            height_next  = '0;
            left_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SKIP;
            tok_reg     <= TOK_MAGIC;
            magic_reg   <= MG_NONE;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            digit_reg   <= 1'b0;
            bad_reg     <= 1'b0;
            started_reg <= 1'b0;
            width_reg   <= '0;
            wf_reg      <= WF_NONE;
            height_reg  <= '0;
            left_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            tok_reg     <= tok_next;
            magic_reg   <= magic_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            digit_reg   <= digit_next;
            bad_reg     <= bad_next;
            started_reg <= started_next;
            width_reg   <= width_next;
            wf_reg      <= wf_next;
            height_reg  <= height_next;
            left_reg    <= left_next;
        end
    end

    // pixel count, ready well before the maxval token ends
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_BITS'(width_reg) * PROD_BITS'(height_reg);
    end

endmodule

[design/pgmp_out_reg.sv]
// pgmp_out_reg: result register of the parser, holds one result item until taken
// depends on pgmp_pkg
module pgmp_out_reg
    import pgmp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  logic      res_valid,
    input  pgmp_out_t res,
    output logic      out_free,
    output logic      m_valid,
    input  logic      m_ready,
    output pgmp_out_t m_data
);

    logic      valid_reg;
    logic      valid_next;
    pgmp_out_t data_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (fire && res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            data_reg <= res;
        end
    end

endmodule

[design/pgm_p5_stream_parser.sv]
// pgm_p5_stream_parser: binary pgm header parser and pixel forwarder, top level
// stages in order: input register, update logic, result register
// throughput: one item per cycle unless a full result register waits on m_ready
// reset: aresetn clears both valid flags and all parser state; an end marker
// item returns the parser to the same state
// depends on pgmp_pkg, pgmp_in_reg, pgmp_core, pgmp_out_reg
module pgm_p5_stream_parser
    import pgmp_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pgmp_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output pgmp_out_t m_data
);

    logic      out_free;
    logic      fire;
    pgmp_in_t  item;
    logic      res_valid;
    pgmp_out_t res;

    pgmp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .fire     (fire),
        .item     (item)
    );

    pgmp_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    pgmp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef ASSERT_OFF
    a_err_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_ERROR) |-> (m_data.error_code <= ERR_LARGE))
        else $error("error item with undefined code");

    a_header_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_HEADER && DIM_BITS <= 16) |->
        (m_data.image_width != 16'd0 && m_data.image_height != 16'd0))
        else $error("header item with zero size");

    a_last_only_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind != KIND_PIXEL) |->
        (!m_data.last_pixel && m_data.pixel == 8'd0))
        else $error("pixel fields set on a non-pixel item");
`endif

endmodule
